>>> rtl/wobp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wobp_pkg;

   // Field and register widths.
   localparam int COEF_BITS    = 16;
   localparam int LEVELS_BITS  = 5;
   localparam int BAND_BITS    = 4;
   localparam int POWER_BITS   = 32;

   // Octave band count limits and reset value.
   localparam int MAX_LEVELS   = 16;
   localparam logic [LEVELS_BITS-1:0] LEVELS_RESET = LEVELS_BITS'(10);
   localparam logic [LEVELS_BITS-1:0] LEVELS_MIN   = LEVELS_BITS'(1);
   localparam logic [LEVELS_BITS-1:0] LEVELS_MAX   = LEVELS_BITS'(MAX_LEVELS);

   // Datapath widths.
   localparam int SQUARE_BITS  = 2 * COEF_BITS;
   localparam int SCALE_BITS   = 2 * COEF_BITS - 1;
   localparam int SUM_BITS     = SCALE_BITS + MAX_LEVELS - 1;
   localparam int FRAC_BITS    = 16;
   localparam int REMAIN_BITS  = MAX_LEVELS;
   localparam int STEP_BITS    = $clog2(POWER_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(POWER_BITS - 1);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic cfg_write;
      logic check;
      logic step;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic band_end;
      logic skip;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> rtl/wobp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wobp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire wobp_pkg::ctrl_status_type status,
   output wobp_pkg::ctrl_cmd_type        cmd
);
   import wobp_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_valid && !csr_valid && status.band_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            if (status.skip) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // Outputs. A register write wins over an input word offered in the same
   // cycle; the input is stalled for that cycle.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_stall     = csr_valid;
            csr_ready     = 1'b1;
            cmd.accept    = req_valid && !csr_valid;
            cmd.cfg_write = csr_valid;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/wobp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wobp_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic signed [wobp_pkg::COEF_BITS-1:0] req_coefficient,
   input  wire logic [wobp_pkg::LEVELS_BITS-1:0]     csr_levels,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic [wobp_pkg::BAND_BITS-1:0]            rsp_band_index,
   output logic [wobp_pkg::POWER_BITS-1:0]           rsp_band_power,
   output logic                                      rsp_last_band,
   input  wire wobp_pkg::ctrl_cmd_type               cmd,
   output wobp_pkg::ctrl_status_type                 status
);
   import wobp_pkg::*;

   // Vector and band tracking.
   logic [LEVELS_BITS-1:0]  levels_ff;
   logic                    scale_seen_ff;
   logic [BAND_BITS-1:0]    band_number_ff;
   logic [REMAIN_BITS-1:0]  band_remaining_ff;
   logic [SUM_BITS-1:0]     square_sum_ff;
   logic [SCALE_BITS-1:0]   scale_square_ff;
   logic                    zero_scale_ff;

   // Captured band and divider.
   logic [BAND_BITS-1:0]    cap_band_ff;
   logic                    cap_last_ff;
   logic                    cap_zero_ff;
   logic [SCALE_BITS-1:0]   rem_ff;
   logic [POWER_BITS-1:0]   low_ff;
   logic [POWER_BITS-1:0]   quot_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic [BAND_BITS-1:0]    rsp_band_ff;
   logic [POWER_BITS-1:0]   rsp_power_ff;
   logic                    rsp_last_ff;

   logic [COEF_BITS-1:0]    mag;
   logic [SQUARE_BITS-1:0]  square;
   logic [SUM_BITS-1:0]     sum_next;
   logic [LEVELS_BITS-1:0]  eff_levels;
   logic                    band_last;
   logic [BAND_BITS-1:0]    band_inc;
   logic                    saturate;
   logic [SCALE_BITS:0]     rem_shift;
   logic [SCALE_BITS:0]     rem_diff;
   logic                    quot_bit;

   always_comb begin
      mag      = req_coefficient[COEF_BITS-1] ? COEF_BITS'(-req_coefficient)
                                              : COEF_BITS'(req_coefficient);
      square   = SQUARE_BITS'(mag) * SQUARE_BITS'(mag);
      sum_next = square_sum_ff + SUM_BITS'(square);

      if (levels_ff < LEVELS_MIN) begin
         eff_levels = LEVELS_MIN;
      end else if (levels_ff > LEVELS_MAX) begin
         eff_levels = LEVELS_MAX;
      end else begin
         eff_levels = levels_ff;
      end
      band_last = (LEVELS_BITS'(band_number_ff) + LEVELS_BITS'(1)) >= eff_levels;
      band_inc  = band_number_ff + BAND_BITS'(1);

      saturate  = rem_ff >= scale_square_ff;
      rem_shift = {rem_ff, low_ff[POWER_BITS-1]};
      rem_diff  = rem_shift - {1'b0, scale_square_ff};
      quot_bit  = rem_shift >= {1'b0, scale_square_ff};
   end

   assign status.band_end = scale_seen_ff && (band_remaining_ff == REMAIN_BITS'(1));
   assign status.skip     = cap_zero_ff || saturate;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Control state of the vector walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff         <= LEVELS_RESET;
         scale_seen_ff     <= 1'b0;
         band_number_ff    <= '0;
         band_remaining_ff <= '0;
         square_sum_ff     <= '0;
         zero_scale_ff     <= 1'b0;
      end else if (cmd.cfg_write) begin
         levels_ff         <= csr_levels;
         scale_seen_ff     <= 1'b0;
         band_number_ff    <= '0;
         band_remaining_ff <= '0;
         square_sum_ff     <= '0;
         zero_scale_ff     <= 1'b0;
      end else if (cmd.accept) begin
         if (!scale_seen_ff) begin
            scale_seen_ff     <= 1'b1;
            zero_scale_ff     <= (square == '0);
            band_number_ff    <= '0;
            band_remaining_ff <= REMAIN_BITS'(1);
            square_sum_ff     <= '0;
         end else if (status.band_end) begin
            square_sum_ff <= '0;
            if (band_last) begin
               scale_seen_ff     <= 1'b0;
               band_number_ff    <= '0;
               band_remaining_ff <= '0;
               zero_scale_ff     <= 1'b0;
            end else begin
               band_number_ff    <= band_inc;
               band_remaining_ff <= REMAIN_BITS'(1) << band_inc;
            end
         end else begin
            square_sum_ff     <= sum_next;
            band_remaining_ff <= band_remaining_ff - REMAIN_BITS'(1);
         end
      end
   end

   // Scale term, band capture and the restoring divider.
   always_ff @(posedge clock) begin
      if (cmd.accept && !scale_seen_ff) begin
         scale_square_ff <= SCALE_BITS'(square);
      end
      if (cmd.accept && status.band_end) begin
         cap_band_ff <= band_number_ff;
         cap_last_ff <= band_last;
         cap_zero_ff <= zero_scale_ff;
         rem_ff      <= SCALE_BITS'(sum_next[SUM_BITS-1:FRAC_BITS]);
         low_ff      <= {sum_next[FRAC_BITS-1:0], {(POWER_BITS-FRAC_BITS){1'b0}}};
      end else if (cmd.step) begin
         rem_ff <= quot_bit ? rem_diff[SCALE_BITS-1:0] : rem_shift[SCALE_BITS-1:0];
         low_ff <= {low_ff[POWER_BITS-2:0], 1'b0};
      end
      if (cmd.check) begin
         quot_ff <= (saturate && !cap_zero_ff) ? '1 : '0;
      end else if (cmd.step) begin
         quot_ff <= {quot_ff[POWER_BITS-2:0], quot_bit};
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_band_ff  <= cap_band_ff;
         rsp_power_ff <= quot_ff;
         rsp_last_ff  <= cap_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_band_index = rsp_band_ff;
   assign rsp_band_power = rsp_power_ff;
   assign rsp_last_band  = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/wavelet_octave_band_power.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Word
// req       in         req_valid / req_stall    req_coefficient
// rsp       out        rsp_valid / rsp_stall    rsp_band_index, rsp_band_power, rsp_last_band
// csr       in         csr_valid / csr_ready    csr_levels
//
// A coefficient that does not close a band is taken without holding off the
// input. A coefficient that closes a band holds off the input while the block
// tests for a zero scaling term or saturation, runs the one-bit-per-cycle
// restoring divider (skipped on either) and loads the result register. The load
// waits while a held result is stalled, and a register write stalls the input.
// Reset is synchronous and returns levels to 10 and the vector to its start.

module wavelet_octave_band_power (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [wobp_pkg::COEF_BITS-1:0] req_coefficient,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [wobp_pkg::BAND_BITS-1:0]            rsp_band_index,
   output logic [wobp_pkg::POWER_BITS-1:0]           rsp_band_power,
   output logic                                      rsp_last_band,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [wobp_pkg::LEVELS_BITS-1:0]     csr_levels
);
   import wobp_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The controller sequences accumulate, check, divide and emit. The
   // configuration port is only open while the block is accumulating.
   wobp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath squares each coefficient, accumulates the band, and divides
   // the band sum by the square of the scaling term into Q16.16.
   wobp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_coefficient (req_coefficient),
      .csr_levels      (csr_levels),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_band_index  (rsp_band_index),
      .rsp_band_power  (rsp_band_power),
      .rsp_last_band   (rsp_last_band),
      .cmd             (cmd),
      .status          (status)
   );

   // A word that closes a band must hold off the input on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && status.band_end) |=> req_stall)
      else $error("input not held off after a band closed");

   // The result register is only loaded when it is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // A loaded result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

   // The divider never runs while input words are being taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (req_stall && !cmd.accept))
      else $error("divider stepping while input open");

endmodule

`default_nettype wire
